@@ hw/rtl/scsa_pkg.sv @@
package scsa_pkg;

  localparam int unsigned MASK_W      = 4;
  localparam int unsigned PORT_W      = 2;
  localparam int unsigned PORTS_DEF   = 4;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned MA_W        = 12;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  // fixed 5 V sink PDO fields (50 mV and 10 mA units)
  localparam logic [9:0] PDO_5V_50MV  = 10'd100;
  localparam logic [9:0] PDO_1A5_10MA = 10'd150;

  localparam logic [1:0] FRS_CUR_NONE = 2'd0;
  localparam logic [1:0] FRS_CUR_3A0  = 2'd3;

  localparam logic [MA_W-1:0] MA_NONE = 12'd0;
  localparam logic [MA_W-1:0] MA_0A5  = 12'd500;
  localparam logic [MA_W-1:0] MA_1A5  = 12'd1500;
  localparam logic [MA_W-1:0] MA_3A0  = 12'd3000;

  localparam logic [1:0] REG_SLOT_COUNT    = 2'd0;
  localparam logic [1:0] REG_FRS_SUPPORTED = 2'd1;
  localparam logic [1:0] REG_ACTIVE_PORTS  = 2'd2;

  localparam logic [2:0] SLOT_COUNT_RST    = 3'd1;
  localparam logic       FRS_SUPPORTED_RST = 1'b1;
  localparam logic [2:0] ACTIVE_PORTS_RST  = 3'd4;

  typedef enum logic [2:0] {
    OP_SINK_PDO      = 3'd0,
    OP_ADD_NONPD     = 3'd1,
    OP_REMOVE_SINK   = 3'd2,
    OP_REMOVE_SOURCE = 3'd3,
    OP_WAIT_EXPIRED  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ACT_DONE       = 3'd0,
    ACT_RP_3A      = 3'd1,
    ACT_RP_DEFAULT = 3'd2,
    ACT_NONPD_DOWN = 3'd3,
    ACT_FRS_ON     = 3'd4,
    ACT_FRS_OFF    = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0] slot_count;
    logic       frs_supported;
    logic [2:0] active_ports;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    logic [PORT_W-1:0] port;
    logic [MASK_W-1:0] claimed;
    logic [MA_W-1:0]   ma;
  } result_t;

  function automatic logic [MASK_W-1:0] port_valid_mask(input int unsigned ports);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      m[i] = (i < ports);
    end
    return m;
  endfunction

  function automatic logic [PORT_W-1:0] pick_low_port(input logic [MASK_W-1:0] m);
    logic [PORT_W-1:0] p;
    p = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        p = PORT_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [MA_W-1:0] offered_ma(input logic src, input logic rp_1a5,
                                                 input logic claimed);
    logic [MA_W-1:0] ma;
    if (!src) begin
      ma = MA_NONE;
    end else if (claimed) begin
      ma = MA_3A0;
    end else if (rp_1a5) begin
      ma = MA_1A5;
    end else begin
      ma = MA_0A5;
    end
    return ma;
  endfunction

endpackage

@@ hw/rtl/scsa_apb_regs.sv @@
module scsa_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scsa_pkg::APB_AW-1:0]  paddr,
  input  logic [scsa_pkg::APB_DW-1:0]  pwdata,
  output logic [scsa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output scsa_pkg::cfg_t               cfg_o
);
  import scsa_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SLOT_COUNT:    cfg_d.slot_count    = pwdata[2:0];
        REG_FRS_SUPPORTED: cfg_d.frs_supported = pwdata[0];
        REG_ACTIVE_PORTS:  cfg_d.active_ports  = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOT_COUNT:    prdata = APB_DW'(cfg_q.slot_count);
      REG_FRS_SUPPORTED: prdata = APB_DW'(cfg_q.frs_supported);
      REG_ACTIVE_PORTS:  prdata = APB_DW'(cfg_q.active_ports);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_count    <= SLOT_COUNT_RST;
      cfg_q.frs_supported <= FRS_SUPPORTED_RST;
      cfg_q.active_ports  <= ACTIVE_PORTS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hw/rtl/source_current_slot_allocator.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+-------------------------------------------------
// in       | in_valid_i / in_stall_o  | op_i port_i pdo_i role_source_i rev_is_20_i
//          |                          | default_rp_1a5_i
// out      | out_valid_o / out_stall_i| action_o action_port_o claimed_mask_o
//          |                          | source_current_ma_o last_o
// cfg      | APB psel/penable/pwrite  | paddr pwdata prdata, pready tied high
//
// Per word: decode, prune, then one port per cycle while no held result is stalled, over
// the three request classes (4 ports x 3 classes) through a single slot compare unit.
// in_stall_o is high from acceptance until the final result is handed to the output
// register. Output stalls always hold the final push; the scan only with a result held.
// Reset clears all request masks, claimed ports and the waiting flag.
module source_current_slot_allocator #(
  parameter int unsigned PORTS = scsa_pkg::PORTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    op_i,
  input  logic [scsa_pkg::PORT_W-1:0]   port_i,
  input  logic [31:0]                   pdo_i,
  input  logic                          role_source_i,
  input  logic                          rev_is_20_i,
  input  logic                          default_rp_1a5_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    action_o,
  output logic [scsa_pkg::PORT_W-1:0]   action_port_o,
  output logic [scsa_pkg::MASK_W-1:0]   claimed_mask_o,
  output logic [scsa_pkg::MA_W-1:0]     source_current_ma_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scsa_pkg::APB_AW-1:0]   paddr,
  input  logic [scsa_pkg::APB_DW-1:0]   pwdata,
  output logic [scsa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import scsa_pkg::*;

  localparam logic [MASK_W-1:0] PortValid = port_valid_mask(PORTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRUNE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    CLS_PD,
    CLS_FRS,
    CLS_NONPD
  } cls_e;

  cfg_t cfg;

  scsa_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic [31:0]       pdo_q, pdo_d;
  logic              src_q, src_d;
  logic              rev_q, rev_d;
  logic              rp_q, rp_d;
  logic [MASK_W-1:0] pd_q, pd_d, frs_q, frs_d, np_q, np_d, claimed_q, claimed_d;
  logic              wait_q, wait_d;
  cls_e              cls_q, cls_d;
  logic [PORT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              held_v_q, held_v_d;
  result_t           held_q, held_d;
  logic              out_v_q, out_v_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              out_free, can_emit;
  logic              emit_req;
  action_e           emit_act;
  logic [PORT_W-1:0] emit_port;
  logic              push;
  result_t           push_data;
  logic              push_last;
  logic [MASK_W-1:0] ev_bit, req, lim_mask, np_claimed, frs_claimed;
  logic [2:0]        cnt;
  logic              pend;
  logic [1:0]        frs_cur;
  logic              pdo_fixed_5v;
  logic [PORT_W-1:0] victim;

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !held_v_q || out_free;
  assign ev_bit   = MASK_W'(1) << port_q;
  assign frs_cur  = pdo_q[24:23];
  assign pdo_fixed_5v = (pdo_q[31:30] == 2'b00) && (pdo_q[19:10] == PDO_5V_50MV);
  assign np_claimed   = np_q & claimed_q;
  assign frs_claimed  = frs_q & claimed_q;

  always_comb begin
    case (cls_q)
      CLS_PD:  req = pd_q;
      CLS_FRS: req = frs_q;
      default: req = np_q;
    endcase
  end

  assign pend = req[idx_q] & ~claimed_q[idx_q] & PortValid[idx_q];

  always_comb begin
    cnt = '0;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      lim_mask[i] = (3'(i) < cfg.active_ports) && PortValid[i];
      cnt = cnt + 3'(claimed_q[i] & lim_mask[i]);
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    port_d     = port_q;
    pdo_d      = pdo_q;
    src_d      = src_q;
    rev_d      = rev_q;
    rp_d       = rp_q;
    pd_d       = pd_q;
    frs_d      = frs_q;
    np_d       = np_q;
    claimed_d  = claimed_q;
    wait_d     = wait_q;
    cls_d      = cls_q;
    idx_d      = idx_q;
    n_d        = n_q;
    held_v_d   = held_v_q;
    held_d     = held_q;
    emit_req   = 1'b0;
    emit_act   = ACT_DONE;
    emit_port  = port_q;
    push       = 1'b0;
    push_data  = held_q;
    push_last  = 1'b0;
    victim     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          port_d  = port_i;
          pdo_d   = pdo_i;
          src_d   = role_source_i;
          rev_d   = rev_is_20_i;
          rp_d    = default_rp_1a5_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_d = ST_FIN;
        if (PortValid[port_q]) begin
          case (op_q)
            OP_SINK_PDO: begin
              if (pdo_fixed_5v) begin
                if (src_q) begin
                  if (cfg.slot_count != '0 && pdo_q[9:0] > PDO_1A5_10MA) begin
                    pd_d    = pd_q | ev_bit;
                    state_d = ST_PRUNE;
                  end
                end else if (cfg.frs_supported && !rev_q && pdo_q[29] &&
                             frs_cur != FRS_CUR_NONE) begin
                  if (frs_cur != FRS_CUR_3A0) begin
                    emit_req = 1'b1;
                    emit_act = ACT_FRS_ON;
                  end else if (cfg.slot_count != '0) begin
                    frs_d   = frs_q | ev_bit;
                    state_d = ST_PRUNE;
                  end
                end
              end
            end
            OP_ADD_NONPD: begin
              if (cfg.slot_count != '0) begin
                np_d    = np_q | ev_bit;
                state_d = ST_PRUNE;
              end
            end
            OP_REMOVE_SINK: begin
              if (cfg.slot_count != '0 && ((pd_q | np_q) & ev_bit) != '0) begin
                pd_d     = pd_q & ~ev_bit;
                np_d     = np_q & ~ev_bit;
                emit_req = 1'b1;
                emit_act = ACT_RP_DEFAULT;
                state_d  = ST_PRUNE;
              end
            end
            OP_REMOVE_SOURCE: begin
              if (cfg.slot_count != '0 && cfg.frs_supported && (frs_q & ev_bit) != '0) begin
                frs_d   = frs_q & ~ev_bit;
                state_d = ST_PRUNE;
              end
            end
            OP_WAIT_EXPIRED: begin
              wait_d  = 1'b0;
              state_d = ST_PRUNE;
            end
            default: ;
          endcase
        end
      end

      ST_PRUNE: begin
        if (wait_q) begin
          state_d = ST_FIN;
        end else begin
          claimed_d = claimed_q & (pd_q | frs_q | np_q);
          cls_d     = CLS_PD;
          idx_d     = '0;
          state_d   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (can_emit) begin
          if (pend && cnt < cfg.slot_count) begin
            claimed_d = claimed_q | (MASK_W'(1) << idx_q);
            emit_req  = 1'b1;
            emit_act  = (cls_q == CLS_FRS) ? ACT_FRS_ON : ACT_RP_3A;
            emit_port = idx_q;
          end else if (pend) begin
            state_d = ST_FIN;
            if (cls_q != CLS_NONPD && np_claimed != '0) begin
              victim    = pick_low_port(np_claimed);
              claimed_d = claimed_q & ~(MASK_W'(1) << victim);
              wait_d    = 1'b1;
              emit_req  = 1'b1;
              emit_act  = ACT_NONPD_DOWN;
              emit_port = victim;
            end else if (cls_q == CLS_PD && frs_claimed != '0) begin
              victim    = pick_low_port(frs_claimed);
              claimed_d = claimed_q & ~(MASK_W'(1) << victim);
              wait_d    = 1'b1;
              emit_req  = 1'b1;
              emit_act  = ACT_FRS_OFF;
              emit_port = victim;
            end
          end
          if (!pend || cnt < cfg.slot_count) begin
            if (idx_q == PORT_W'(MASK_W - 1)) begin
              idx_d = '0;
              case (cls_q)
                CLS_PD:  cls_d = CLS_FRS;
                CLS_FRS: cls_d = CLS_NONPD;
                default: state_d = ST_FIN;
              endcase
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (held_v_q) begin
            push_data = held_q;
          end else begin
            push_data.action  = ACT_DONE;
            push_data.port    = port_q;
            push_data.claimed = claimed_q;
            push_data.ma      = offered_ma(src_q, rp_q, claimed_q[port_q]);
          end
          held_v_d = 1'b0;
          n_d      = '0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // results past the limit are dropped, state still moves
    if (emit_req && n_q != CNT_W'(MAX_RESULTS)) begin
      if (held_v_q) begin
        push      = 1'b1;
        push_data = held_q;
      end
      n_d            = n_q + 1'b1;
      held_v_d       = 1'b1;
      held_d.action  = emit_act;
      held_d.port    = emit_port;
      held_d.claimed = claimed_d;
      held_d.ma      = offered_ma(src_q, rp_q, claimed_d[port_q]);
    end
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_d      = push_data;
      out_last_d = push_last;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pd_q       <= '0;
      frs_q      <= '0;
      np_q       <= '0;
      claimed_q  <= '0;
      wait_q     <= 1'b0;
      cls_q      <= CLS_PD;
      idx_q      <= '0;
      n_q        <= '0;
      held_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pd_q       <= pd_d;
      frs_q      <= frs_d;
      np_q       <= np_d;
      claimed_q  <= claimed_d;
      wait_q     <= wait_d;
      cls_q      <= cls_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      held_v_q   <= held_v_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    port_q <= port_d;
    pdo_q  <= pdo_d;
    src_q  <= src_d;
    rev_q  <= rev_d;
    rp_q   <= rp_d;
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_v_q;
  assign action_o            = out_q.action;
  assign action_port_o       = out_q.port;
  assign claimed_mask_o      = out_q.claimed;
  assign source_current_ma_o = out_q.ma;
  assign last_o              = out_last_q;

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !held_v_q)
    else $error("pending result left over in idle");

  a_claimed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (claimed_q & ~PortValid) == '0)
    else $error("slot claimed by a port outside the configured range");

  a_wait_from_preempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wait_q) |-> held_v_q &&
      (held_q.action == ACT_NONPD_DOWN || held_q.action == ACT_FRS_OFF))
    else $error("wait started without a preemption result");

endmodule
